>>> hdl/gcs_pkg.sv
// Shared types and codes for the gradient color stop table.
// No dependencies; used by the channel interfaces and the top level.
package gcs_pkg;

  localparam int POS_W   = 17;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 4 * CHAN_W;
  localparam int SLOT_W  = 4;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic              side;
    logic [POS_W-1:0]  position;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              in_range;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
  } rsp_t;

  // one stored stop; color is R in the top byte down to A in the bottom byte
  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
  } stop_t;

endpackage

>>> hdl/gcs_cmd_if.sv
// Command channel: valid/ready handshake carrying one cmd_t item.
// Depends on gcs_pkg.
interface gcs_cmd_if import gcs_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/gcs_rsp_if.sv
// Response channel: valid/ready handshake carrying one rsp_t item.
// Depends on gcs_pkg.
interface gcs_rsp_if import gcs_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/gradient_color_stop_table.sv
// Gradient color stop table: two sorted stop tables with insert, remove and sample.
// Depends on gcs_pkg, gcs_cmd_if and gcs_rsp_if.
//
//   channel | dir | payload | handshake
//   --------+-----+---------+--------------------------------
//   cmd     | in  | cmd_t   | valid/ready, item taken on both high
//   rsp     | out | rsp_t   | valid/ready, one item per command
//
// Steps from accept to result: insert moves each larger stop up one place,
//   then writes the new stop below them; remove pulls each later stop down
//   one place; sample scans neighboring pairs, then runs the four channel
//   divides (one shared 8x17 multiplier and one restoring divider, per channel).
// One item at a time: cmd.ready is high only while the sequencer is idle.
// The result register is separate, so a new item is taken while the last
//   result waits; the sequencer holds in its final state if rsp stalls.
// Reset clears the stop counts; the stop memory itself needs no clearing,
//   since only entries below a side's count are ever read.
module gradient_color_stop_table
  import gcs_pkg::*;
#(
  parameter int MAX_STOPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  gcs_cmd_if.sink   cmd,
  gcs_rsp_if.source rsp
);

  localparam int IW = $clog2(MAX_STOPS);      // index within one side
  localparam int CW = $clog2(MAX_STOPS + 1);  // stop count
  localparam int XW = IW + 1;                 // index plus one, for compares
  localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int AW = IW + 1;                 // {side, index}
  localparam int MEM_DEPTH = 2 ** AW;
  localparam int PROD_W = CHAN_W + POS_W;

  typedef enum logic [3:0] {
    IDLE, INS_STEP, INS_RD, INS_CHK, REM_STEP, REM_RD, REM_WR,
    SMP_RD, SMP_CHK, MUL, DIV, CH_END, DONE
  } state_t;

  state_t state;

  // latched command
  logic               sd;
  logic [POS_W-1:0]   pos_q;
  logic [COLOR_W-1:0] new_color;

  logic [CW-1:0] cnt [2];
  logic [IW-1:0] idx;

  // sample datapath
  stop_t              prev;
  logic [COLOR_W-1:0] c0w;
  logic [COLOR_W-1:0] c1w;
  logic [POS_W-1:0]   d_q;
  logic [POS_W-1:0]   e_q;
  logic [1:0]         ch;
  logic [2:0]         k;
  logic [POS_W-1:0]   rem;
  logic [CHAN_W-1:0]  lo;     // low dividend bits shift out, quotient bits shift in
  logic               neg;
  logic [CHAN_W-1:0]  c0b;
  rsp_t               res;

  // stop memory, one write and one registered read port
  stop_t         mem [MEM_DEPTH];
  stop_t         rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  stop_t         wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // control terms
  logic [CW-1:0] n;
  logic [XW-1:0] idx_inc;
  logic          more_left;
  logic          shift_up;
  stop_t         new_stop;

  assign n         = cnt[sd];
  assign idx_inc   = XW'(idx) + XW'(1);
  assign more_left = idx_inc < XW'(n);
  assign shift_up  = pos_q < rd_data.pos;
  assign new_stop  = '{pos: pos_q, color: new_color};

  always_comb begin
    unique case (state)
      INS_RD:  rd_addr = {sd, idx - IW'(1)};
      REM_RD:  rd_addr = {sd, idx_inc[IW-1:0]};
      default: rd_addr = {sd, idx};
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {sd, idx};
    wr_data = new_stop;
    unique case (state)
      INS_STEP: wr_en = (idx == '0);
      INS_CHK: begin
        wr_en   = 1'b1;
        wr_data = shift_up ? rd_data : new_stop;
      end
      REM_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // channel select, red first
  logic [CHAN_W-1:0] c0_ch;
  logic [CHAN_W-1:0] c1_ch;

  always_comb begin
    unique case (ch)
      2'd0: begin c0_ch = c0w[31:24]; c1_ch = c1w[31:24]; end
      2'd1: begin c0_ch = c0w[23:16]; c1_ch = c1w[23:16]; end
      2'd2: begin c0_ch = c0w[15:8];  c1_ch = c1w[15:8];  end
      default: begin c0_ch = c0w[7:0]; c1_ch = c1w[7:0]; end
    endcase
  end

  // shared multiplier and one restoring divide step
  logic              ch_neg;
  logic [CHAN_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic [POS_W:0]    trial;
  logic [POS_W:0]    diff;
  logic              q_bit;
  logic [POS_W-1:0]  rem_next;
  logic [CHAN_W-1:0] ch_val;

  assign ch_neg   = c1_ch < c0_ch;
  assign mag      = ch_neg ? (c0_ch - c1_ch) : (c1_ch - c0_ch);
  assign prod     = PROD_W'(mag) * PROD_W'(e_q);
  assign trial    = {rem, lo[CHAN_W-1]};
  assign diff     = trial - {1'b0, d_q};
  assign q_bit    = trial >= {1'b0, d_q};
  assign rem_next = q_bit ? diff[POS_W-1:0] : trial[POS_W-1:0];
  assign ch_val   = neg ? (c0b - lo) : (c0b + lo);

  assign cmd.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // DONE refills the result register itself when it is taken
      if (rsp.valid && rsp.ready && state != DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (cmd.valid) begin
            sd        <= cmd.data.side;
            pos_q     <= cmd.data.position;
            new_color <= {cmd.data.red_in, cmd.data.green_in,
                          cmd.data.blue_in, cmd.data.alpha_in};
            case (cmd.data.action)
              ACT_INSERT: begin
                if (cnt[cmd.data.side] >= CW'(MAX_STOPS)) begin
                  res   <= {ST_FULL, {(1 + COLOR_W){1'b0}}};
                  state <= DONE;
                end else begin
                  res   <= '0;
                  idx   <= IW'(cnt[cmd.data.side]);
                  state <= INS_STEP;
                end
              end
              ACT_REMOVE: begin
                if (SW'(cmd.data.slot) >= SW'(cnt[cmd.data.side])) begin
                  res   <= {ST_RANGE, {(1 + COLOR_W){1'b0}}};
                  state <= DONE;
                end else begin
                  res   <= '0;
                  idx   <= IW'(cmd.data.slot);
                  state <= REM_STEP;
                end
              end
              ACT_SAMPLE: begin
                res   <= '0;
                idx   <= '0;
                state <= (cnt[cmd.data.side] < CW'(2)) ? DONE : SMP_RD;
              end
              default: begin
                res   <= '0;
                state <= DONE;
              end
            endcase
          end
        end
        // insert: walk down from the top, moving larger stops up one place
        INS_STEP: begin
          if (idx == '0) begin
            cnt[sd] <= n + CW'(1);
            state   <= DONE;
          end else begin
            state <= INS_RD;
          end
        end
        INS_RD: state <= INS_CHK;
        INS_CHK: begin
          if (shift_up) begin
            idx   <= idx - IW'(1);
            state <= INS_STEP;
          end else begin
            cnt[sd] <= n + CW'(1);
            state   <= DONE;
          end
        end
        // remove: pull each later stop down one place
        REM_STEP: begin
          if (more_left) begin
            state <= REM_RD;
          end else begin
            cnt[sd] <= n - CW'(1);
            state   <= DONE;
          end
        end
        REM_RD: state <= REM_WR;
        REM_WR: begin
          idx   <= idx_inc[IW-1:0];
          state <= REM_STEP;
        end
        // sample: scan neighboring pairs for the first one holding t
        SMP_RD: state <= SMP_CHK;
        SMP_CHK: begin
          if (idx == '0) begin
            prev  <= rd_data;
            idx   <= IW'(1);
            state <= SMP_RD;
          end else if (prev.pos <= pos_q && pos_q <= rd_data.pos) begin
            res.in_range <= 1'b1;
            c0w          <= prev.color;
            c1w          <= rd_data.color;
            d_q          <= rd_data.pos - prev.pos;
            e_q          <= pos_q - prev.pos;
            ch           <= 2'd0;
            if (rd_data.pos == prev.pos) begin
              // zero-length segment gives its start color
              res.red_out   <= prev.color[31:24];
              res.green_out <= prev.color[23:16];
              res.blue_out  <= prev.color[15:8];
              res.alpha_out <= prev.color[7:0];
              state         <= DONE;
            end else begin
              state <= MUL;
            end
          end else begin
            prev <= rd_data;
            if (more_left) begin
              idx   <= idx_inc[IW-1:0];
              state <= SMP_RD;
            end else begin
              state <= DONE;
            end
          end
        end
        // e <= d, so the quotient fits 8 bits and the top 17 product bits
        // are already below d: eight restoring steps finish the divide
        MUL: begin
          rem   <= prod[PROD_W-1:CHAN_W];
          lo    <= prod[CHAN_W-1:0];
          neg   <= ch_neg;
          c0b   <= c0_ch;
          k     <= '0;
          state <= DIV;
        end
        DIV: begin
          rem <= rem_next;
          lo  <= {lo[CHAN_W-2:0], q_bit};
          k   <= k + 3'd1;
          if (k == 3'd7) begin
            state <= CH_END;
          end
        end
        CH_END: begin
          case (ch)
            2'd0:    res.red_out   <= ch_val;
            2'd1:    res.green_out <= ch_val;
            2'd2:    res.blue_out  <= ch_val;
            default: res.alpha_out <= ch_val;
          endcase
          if (ch == 2'd3) begin
            state <= DONE;
          end else begin
            ch    <= ch + 2'd1;
            state <= MUL;
          end
        end
        DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.data  <= res;
            rsp.valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // counts never pass the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= CW'(MAX_STOPS) && cnt[1] <= CW'(MAX_STOPS))
    else $error("stop count above table size");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("second item taken while busy");

  // no segment found means zero color
  a_zero_color: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.in_range |->
      rsp.data.red_out == '0 && rsp.data.green_out == '0 &&
      rsp.data.blue_out == '0 && rsp.data.alpha_out == '0)
    else $error("color without a segment");

  // an error status never comes with a sample hit
  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status != ST_OK |-> !rsp.data.in_range)
    else $error("error status with in_range set");

endmodule
